// File: rtl/ttl_kv_pkg.sv
// ----------------------------------------------------------------------------
// ttl_kv_pkg
// Types, codes and default sizes for the key/value table with entry lifetimes.
// ----------------------------------------------------------------------------
package ttl_kv_pkg;

	localparam int unsigned ENTRIES_DEF    = 64;
	localparam int unsigned KEY_BITS_DEF   = 32;
	localparam int unsigned VALUE_BITS_DEF = 32;

	localparam int unsigned TIME_BITS    = 48;
	localparam int unsigned LIFE_BITS    = 32;
	localparam int unsigned CFG_BITS     = 32;
	localparam int unsigned CFG_IDX_BITS = 3;

	typedef enum logic [1:0] {
		CMD_GET  = 2'd0,
		CMD_SET  = 2'd1,
		CMD_DEL  = 2'd2,
		CMD_TICK = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MIN_DURATION     = 3'd0,
		CFG_DEFAULT_DURATION = 3'd1,
		CFG_DEFAULT_INFINITE = 3'd2,
		CFG_MIN_SWEEP_GAP    = 3'd3,
		CFG_MAX_SWEEP_GAP    = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_GET_EVAL,
		ST_GET_CLAMP,
		ST_SET_WRITE,
		ST_TICK_ELAPSED,
		ST_TICK_DECIDE,
		ST_RESP
	} state_t;

endpackage

// File: rtl/ttl_key_value_table_core.sv
// ----------------------------------------------------------------------------
// ttl_key_value_table_core
// Bounded key/value table whose entries carry a lifetime. One entry memory
// is scanned an entry a cycle to find keys, free slots and expired entries.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_write              cfg_index, cfg_data
//   in       in         in_valid / in_ready    cmd, lookup_key, write_value,
//                                              lifetime, lifetime_infinite,
//                                              now_time
//   out      out        out_valid / out_ready  status, read_value, remaining,
//                                              remaining_infinite
//
// get, set and delete scan the entry memory and stop early when the key is
// found; a tick passes ST_TICK_ELAPSED and ST_TICK_DECIDE, and then sweeps
// the whole memory for expired entries only when a sweep is due.
// reset clears the valid bits at once; no clearing pass is needed.
// the next item is taken while a result still waits in the output register;
// a further result holds the sequencer until out_ready frees that register.
// ----------------------------------------------------------------------------
module ttl_key_value_table_core #(
	parameter int unsigned ENTRIES    = ttl_kv_pkg::ENTRIES_DEF,
	parameter int unsigned KEY_BITS   = ttl_kv_pkg::KEY_BITS_DEF,
	parameter int unsigned VALUE_BITS = ttl_kv_pkg::VALUE_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_write,
	input  logic [ttl_kv_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [ttl_kv_pkg::CFG_BITS-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           cmd,
	input  logic [KEY_BITS-1:0]                  lookup_key,
	input  logic [VALUE_BITS-1:0]                write_value,
	input  logic [ttl_kv_pkg::LIFE_BITS-1:0]     lifetime,
	input  logic                                 lifetime_infinite,
	input  logic [ttl_kv_pkg::TIME_BITS-1:0]     now_time,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           status,
	output logic [VALUE_BITS-1:0]                read_value,
	output logic [ttl_kv_pkg::LIFE_BITS-1:0]     remaining,
	output logic                                 remaining_infinite
);

	localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int unsigned TB = ttl_kv_pkg::TIME_BITS;
	localparam int unsigned LB = ttl_kv_pkg::LIFE_BITS;
	localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

	ttl_kv_pkg::state_t state_q, state_d;

	// configuration
	logic [LB-1:0] min_dur_q, def_dur_q, min_gap_q, max_gap_q;
	logic          def_inf_q;

	// captured item
	ttl_kv_pkg::cmd_t cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q;
	logic [TB-1:0]         now_q;
	logic [LB-1:0]         eff_life_q;
	logic                  eff_forever_q;

	// table state
	logic [ENTRIES-1:0] valid_q;
	logic [TB-1:0]      last_sweep_q;
	logic               sweep_req_q;

	logic [KEY_BITS-1:0]   mem_key     [ENTRIES];
	logic [VALUE_BITS-1:0] mem_value   [ENTRIES];
	logic [TB-1:0]         mem_stamp   [ENTRIES];
	logic [LB-1:0]         mem_life    [ENTRIES];
	logic                  mem_forever [ENTRIES];

	// scan
	logic [AW-1:0]         issue_idx_q;
	logic                  issue_done_q;
	logic                  rd_vld_s1;
	logic [AW-1:0]         rd_tag_s1;
	logic [KEY_BITS-1:0]   rd_key_s1;
	logic [VALUE_BITS-1:0] rd_value_s1;
	logic [TB-1:0]         rd_stamp_s1;
	logic [LB-1:0]         rd_life_s1;
	logic                  rd_forever_s1;

	logic          hit_q, free_found_q;
	logic [AW-1:0] hit_idx_q, free_idx_q;
	logic [TB:0]   sum_q;
	logic [TB-1:0] hit_stamp_q;
	logic [LB-1:0] hit_life_q;
	logic          hit_forever_q, hit_exp_q;
	logic [TB-1:0] el_q;

	// pending result and output register
	ttl_kv_pkg::status_t   res_status_q;
	logic [VALUE_BITS-1:0] res_value_q;
	logic [LB-1:0]         res_rem_q;
	logic                  res_inf_q;
	logic                  out_valid_q;
	ttl_kv_pkg::status_t   out_status_q;
	logic [VALUE_BITS-1:0] out_value_q;
	logic [LB-1:0]         out_rem_q;
	logic                  out_inf_q;

	logic          in_acc, scan_chk, scan_match, scan_exp, scan_end;
	logic [TB:0]   scan_sum, rem_diff;
	logic          mem_we, sweep_go, resp_load;
	logic [AW-1:0] mem_waddr;

	assign in_acc     = in_valid && in_ready;
	assign scan_chk   = (state_q == ttl_kv_pkg::ST_SCAN) && rd_vld_s1;
	assign scan_match = valid_q[rd_tag_s1] && (rd_key_s1 == key_q);
	assign scan_sum   = {1'b0, rd_stamp_s1} + (TB+1)'(rd_life_s1);
	assign scan_exp   = !rd_forever_s1 && (scan_sum <= {1'b0, now_q});
	assign scan_end   = issue_done_q && !rd_vld_s1;
	assign rem_diff   = sum_q - {1'b0, now_q};

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttl_kv_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = (ttl_kv_pkg::cmd_t'(cmd) == ttl_kv_pkg::CMD_TICK) ?
						ttl_kv_pkg::ST_TICK_ELAPSED : ttl_kv_pkg::ST_SCAN;
				end
			end
			ttl_kv_pkg::ST_SCAN: begin
				if (scan_chk && scan_match && cmd_q != ttl_kv_pkg::CMD_TICK) begin
					unique case (cmd_q)
						ttl_kv_pkg::CMD_GET: state_d = ttl_kv_pkg::ST_GET_EVAL;
						ttl_kv_pkg::CMD_SET: state_d = ttl_kv_pkg::ST_SET_WRITE;
						default:             state_d = ttl_kv_pkg::ST_RESP;
					endcase
				end else if (scan_end) begin
					state_d = (cmd_q == ttl_kv_pkg::CMD_SET) ?
						ttl_kv_pkg::ST_SET_WRITE : ttl_kv_pkg::ST_RESP;
				end
			end
			ttl_kv_pkg::ST_GET_EVAL: begin
				state_d = (!hit_exp_q && !hit_forever_q) ?
					ttl_kv_pkg::ST_GET_CLAMP : ttl_kv_pkg::ST_RESP;
			end
			ttl_kv_pkg::ST_GET_CLAMP:    state_d = ttl_kv_pkg::ST_RESP;
			ttl_kv_pkg::ST_SET_WRITE:    state_d = ttl_kv_pkg::ST_RESP;
			ttl_kv_pkg::ST_TICK_ELAPSED: state_d = ttl_kv_pkg::ST_TICK_DECIDE;
			ttl_kv_pkg::ST_TICK_DECIDE: begin
				state_d = sweep_go ? ttl_kv_pkg::ST_SCAN : ttl_kv_pkg::ST_RESP;
			end
			ttl_kv_pkg::ST_RESP: begin
				if (!out_valid_q || out_ready) begin
					state_d = ttl_kv_pkg::ST_IDLE;
				end
			end
			default: state_d = ttl_kv_pkg::ST_IDLE;
		endcase
	end

	// control outputs of the sequencer
	always_comb begin
		in_ready  = (state_q == ttl_kv_pkg::ST_IDLE);
		mem_we    = (state_q == ttl_kv_pkg::ST_SET_WRITE) && (hit_q || free_found_q);
		mem_waddr = hit_q ? hit_idx_q : free_idx_q;
		sweep_go  = (sweep_req_q && (el_q >= TB'(min_gap_q))) || (el_q >= TB'(max_gap_q));
		resp_load = (state_q == ttl_kv_pkg::ST_RESP) && (!out_valid_q || out_ready);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ttl_kv_pkg::ST_IDLE;
			min_dur_q    <= '0;
			def_dur_q    <= '0;
			def_inf_q    <= 1'b1;
			min_gap_q    <= '0;
			max_gap_q    <= LB'(1000);
			valid_q      <= '0;
			last_sweep_q <= '0;
			sweep_req_q  <= 1'b0;
			issue_idx_q  <= '0;
			issue_done_q <= 1'b0;
			rd_vld_s1    <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (cfg_write) begin
				unique case (ttl_kv_pkg::cfg_idx_t'(cfg_index))
					ttl_kv_pkg::CFG_MIN_DURATION:     min_dur_q <= cfg_data[LB-1:0];
					ttl_kv_pkg::CFG_DEFAULT_DURATION: def_dur_q <= cfg_data[LB-1:0];
					ttl_kv_pkg::CFG_DEFAULT_INFINITE: def_inf_q <= cfg_data[0];
					ttl_kv_pkg::CFG_MIN_SWEEP_GAP:    min_gap_q <= cfg_data[LB-1:0];
					ttl_kv_pkg::CFG_MAX_SWEEP_GAP:    max_gap_q <= cfg_data[LB-1:0];
					default: ;
				endcase
			end

			// address sequencer for the entry memory
			if (state_q != ttl_kv_pkg::ST_SCAN) begin
				issue_idx_q  <= '0;
				issue_done_q <= 1'b0;
			end else if (!issue_done_q) begin
				issue_idx_q <= issue_idx_q + AW'(1);
				if (issue_idx_q == LAST_IDX) begin
					issue_done_q <= 1'b1;
				end
			end
			rd_vld_s1 <= (state_q == ttl_kv_pkg::ST_SCAN) && !issue_done_q;

			if (in_acc) begin
				hit_q        <= 1'b0;
				free_found_q <= 1'b0;
			end else if (scan_chk) begin
				if (scan_match) begin
					hit_q <= 1'b1;
				end
				if (!valid_q[rd_tag_s1] && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end

			if (mem_we) begin
				valid_q[mem_waddr] <= 1'b1;
			end else if (scan_chk && cmd_q == ttl_kv_pkg::CMD_DEL && scan_match) begin
				valid_q[rd_tag_s1] <= 1'b0;
			end else if (scan_chk && cmd_q == ttl_kv_pkg::CMD_TICK &&
			             valid_q[rd_tag_s1] && scan_exp) begin
				valid_q[rd_tag_s1] <= 1'b0;
			end

			if (state_q == ttl_kv_pkg::ST_GET_EVAL && hit_exp_q) begin
				sweep_req_q <= 1'b1;
			end else if (state_q == ttl_kv_pkg::ST_TICK_DECIDE) begin
				sweep_req_q <= 1'b0;
			end

			if (state_q == ttl_kv_pkg::ST_TICK_DECIDE && sweep_go) begin
				last_sweep_q <= now_q;
			end

			if (resp_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q        <= ttl_kv_pkg::cmd_t'(cmd);
			key_q        <= lookup_key;
			val_q        <= write_value;
			now_q        <= now_time;
			res_status_q <= ttl_kv_pkg::STS_OK;
			res_value_q  <= '0;
			res_rem_q    <= '0;
			res_inf_q    <= 1'b0;
			if (lifetime_infinite) begin
				eff_forever_q <= 1'b1;
				eff_life_q    <= '0;
			end else if (lifetime == '0) begin
				eff_forever_q <= def_inf_q;
				eff_life_q    <= def_dur_q;
			end else begin
				eff_forever_q <= 1'b0;
				eff_life_q    <= (lifetime < min_dur_q) ? min_dur_q : lifetime;
			end
		end

		if (scan_chk) begin
			if (scan_match) begin
				hit_idx_q <= rd_tag_s1;
				if (cmd_q == ttl_kv_pkg::CMD_GET) begin
					res_value_q   <= rd_value_s1;
					hit_stamp_q   <= rd_stamp_s1;
					hit_life_q    <= rd_life_s1;
					hit_forever_q <= rd_forever_s1;
					hit_exp_q     <= scan_exp;
					sum_q         <= scan_sum;
				end
			end
			if (!valid_q[rd_tag_s1] && !free_found_q) begin
				free_idx_q <= rd_tag_s1;
			end
		end

		if (state_q == ttl_kv_pkg::ST_SCAN && scan_end &&
		    (cmd_q == ttl_kv_pkg::CMD_GET || cmd_q == ttl_kv_pkg::CMD_DEL)) begin
			res_status_q <= ttl_kv_pkg::STS_NOT_FOUND;
		end

		if (state_q == ttl_kv_pkg::ST_GET_EVAL) begin
			if (hit_exp_q) begin
				res_status_q <= ttl_kv_pkg::STS_NOT_FOUND;
				res_value_q  <= '0;
			end else if (hit_forever_q) begin
				res_inf_q <= 1'b1;
			end else begin
				res_rem_q <= (now_q < hit_stamp_q) ? hit_life_q : rem_diff[LB-1:0];
			end
		end

		if (state_q == ttl_kv_pkg::ST_GET_CLAMP && res_rem_q < min_dur_q) begin
			res_rem_q <= min_dur_q;
		end

		if (state_q == ttl_kv_pkg::ST_SET_WRITE && !mem_we) begin
			res_status_q <= ttl_kv_pkg::STS_FULL;
		end

		if (state_q == ttl_kv_pkg::ST_TICK_ELAPSED) begin
			el_q <= (now_q >= last_sweep_q) ? (now_q - last_sweep_q) : '0;
		end

		if (resp_load) begin
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
			out_rem_q    <= res_rem_q;
			out_inf_q    <= res_inf_q;
		end
	end

	// entry memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_key[mem_waddr]     <= key_q;
			mem_value[mem_waddr]   <= val_q;
			mem_stamp[mem_waddr]   <= now_q;
			mem_life[mem_waddr]    <= eff_life_q;
			mem_forever[mem_waddr] <= eff_forever_q;
		end
		rd_tag_s1     <= issue_idx_q;
		rd_key_s1     <= mem_key[issue_idx_q];
		rd_value_s1   <= mem_value[issue_idx_q];
		rd_stamp_s1   <= mem_stamp[issue_idx_q];
		rd_life_s1    <= mem_life[issue_idx_q];
		rd_forever_s1 <= mem_forever[issue_idx_q];
	end

	assign out_valid          = out_valid_q;
	assign status             = out_status_q;
	assign read_value         = out_value_q;
	assign remaining          = out_rem_q;
	assign remaining_infinite = out_inf_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> state_q != ttl_kv_pkg::ST_IDLE)
		else $error("accepted item did not start work");

	a_read_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> $past(state_q == ttl_kv_pkg::ST_SCAN))
		else $error("entry read outside a scan");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_status_q == ttl_kv_pkg::STS_OK ||
		                 out_status_q == ttl_kv_pkg::STS_NOT_FOUND ||
		                 out_status_q == ttl_kv_pkg::STS_FULL))
		else $error("reserved status code");

	a_infinite_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_inf_q) |-> (out_rem_q == '0 &&
		                                 out_status_q == ttl_kv_pkg::STS_OK))
		else $error("infinite lifetime with remaining time or bad status");

	a_miss_no_value: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_status_q != ttl_kv_pkg::STS_OK) |->
		(out_value_q == '0 && out_rem_q == '0 && !out_inf_q))
		else $error("failed item returned data");

endmodule
